FILE: hw/rtl/lcs_pkg.sv
// Shared widths and sequencer codes for the combination stepper.
`default_nettype none

package lcs_pkg;

    // Stored element value: wide enough for any universe the 9-bit register can name.
    localparam int VAL_W     = 9;
    // Compare width for value + k against position + n.
    localparam int CMP_W     = 11;

    localparam int KSIZE_W   = 5;
    localparam int NSIZE_W   = 9;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DAT_W = 9;

    localparam int STEP_W    = 16;
    localparam int ELEM_W    = 8;
    localparam int POS_W     = 4;
    localparam int M_DATA_W  = 16;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_SUBSET_SIZE   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_UNIVERSE_SIZE = 1'b1;

    // Request kinds.
    localparam logic KIND_RESTART = 1'b0;
    localparam logic KIND_ADVANCE = 1'b1;

    // Sequencer states.
    localparam int ST_W = 3;
    localparam logic [ST_W-1:0] ST_IDLE    = 3'd0;
    localparam logic [ST_W-1:0] ST_SCAN_RD = 3'd1;
    localparam logic [ST_W-1:0] ST_SCAN_CK = 3'd2;
    localparam logic [ST_W-1:0] ST_FILL    = 3'd3;
    localparam logic [ST_W-1:0] ST_EMIT_RD = 3'd4;
    localparam logic [ST_W-1:0] ST_EMIT_LD = 3'd5;
    localparam logic [ST_W-1:0] ST_EMIT_WT = 3'd6;

endpackage

`default_nettype wire

FILE: hw/rtl/lcs_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module lcs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                      aclk,
    input  wire logic                                      wr_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]                          wr_data,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic      [WIDTH-1:0]                          rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

FILE: hw/rtl/lexicographic_combination_stepper.sv
// Restart: streams the k elements, each through the EMIT_RD, EMIT_LD and EMIT_WT states.
// Advance: each successor step reads and checks positions from the right (SCAN_RD, SCAN_CK),
//   then refills each later position in FILL; the combination is then emitted as on restart.
// Throughput: one request at a time; s_tready is high only between requests.
// Pace is set by the single read port of the combination RAM and one shared comparator.
// Reset (aresetn low, synchronous): k = 1, n = 256, combination reads as 0,1,2,...
`default_nettype none

module lexicographic_combination_stepper #(
    parameter int MAX_SUBSET   = 16,
    parameter int MAX_UNIVERSE = 256
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    // configuration write channel
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [lcs_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [lcs_pkg::CFG_DAT_W-1:0]   cfg_data,
    // request channel
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    input  wire logic [lcs_pkg::STEP_W-1:0]      s_tdata,   // [15:0] step_count
    input  wire logic                            s_tuser,   // [0] kind
    // result channel
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic      [lcs_pkg::M_DATA_W-1:0]    m_tdata,   // [7:0] element, [11:8] position
    output logic                                 m_tlast,
    output logic                                 m_tuser    // [0] exhausted
);

    import lcs_pkg::*;

    localparam int IDX_W = (MAX_SUBSET > 1) ? $clog2(MAX_SUBSET) : 1;
    localparam int K_W   = $clog2(MAX_SUBSET + 1);

    logic [ST_W-1:0]       state_reg, state_next;
    logic [IDX_W-1:0]      idx_reg, idx_next;
    logic [STEP_W-1:0]     steps_reg, steps_next;
    logic [VAL_W-1:0]      fill_reg, fill_next;
    logic                  exh_reg, exh_next;
    logic [MAX_SUBSET-1:0] valid_reg, valid_next;
    logic [KSIZE_W-1:0]    subset_size_reg;
    logic [NSIZE_W-1:0]    universe_size_reg;
    logic                  m_valid_reg, m_valid_next;
    logic [ELEM_W-1:0]     m_elem_reg, m_elem_next;
    logic [POS_W-1:0]      m_pos_reg, m_pos_next;
    logic                  m_last_reg, m_last_next;

    logic [K_W-1:0]        k_eff;
    logic [NSIZE_W-1:0]    n_eff;
    logic [IDX_W-1:0]      k_last;
    logic [VAL_W-1:0]      ram_rdata;
    logic [VAL_W-1:0]      cur_val;
    logic                  below_ceiling;
    logic                  wr_en;
    logic [VAL_W-1:0]      wr_data;
    logic                  is_last_pos;

    // Clamp the configured sizes to what the storage supports.
    always_comb begin
        if (subset_size_reg == '0) begin
            k_eff = K_W'(1);
        end else if (int'(subset_size_reg) > MAX_SUBSET) begin
            k_eff = K_W'(MAX_SUBSET);
        end else begin
            k_eff = K_W'(subset_size_reg);
        end
        if (int'(universe_size_reg) > MAX_UNIVERSE) begin
            n_eff = NSIZE_W'(MAX_UNIVERSE);
        end else begin
            n_eff = universe_size_reg;
        end
    end

    assign k_last      = IDX_W'(k_eff - K_W'(1));
    assign is_last_pos = (idx_reg == k_last);

    lcs_ram #(
        .WIDTH (VAL_W),
        .DEPTH (MAX_SUBSET)
    ) u_comb_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (idx_reg),
        .wr_data (wr_data),
        .rd_addr (idx_reg),
        .rd_data (ram_rdata)
    );

    // An entry not written since restart reads as its own position.
    assign cur_val = valid_reg[idx_reg] ? ram_rdata : VAL_W'(idx_reg);

    // value < i + n - k, rearranged to stay non-negative
    assign below_ceiling = (CMP_W'(cur_val) + CMP_W'(k_eff)) <
                           (CMP_W'(idx_reg) + CMP_W'(n_eff));

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == ST_IDLE);
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = {{(M_DATA_W - ELEM_W - POS_W){1'b0}}, m_pos_reg, m_elem_reg};
    assign m_tlast   = m_last_reg;
    assign m_tuser   = exh_reg;

    always_comb begin
        state_next   = state_reg;
        idx_next     = idx_reg;
        steps_next   = steps_reg;
        fill_next    = fill_reg;
        exh_next     = exh_reg;
        valid_next   = valid_reg;
        m_valid_next = m_valid_reg;
        m_elem_next  = m_elem_reg;
        m_pos_next   = m_pos_reg;
        m_last_next  = m_last_reg;
        wr_en        = 1'b0;
        wr_data      = fill_reg + VAL_W'(1);

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    exh_next = 1'b0;
                    if (s_tuser == KIND_RESTART) begin
                        valid_next = '0;
                        idx_next   = '0;
                        state_next = ST_EMIT_RD;
                    end else if (s_tdata == '0) begin
                        idx_next   = '0;
                        state_next = ST_EMIT_RD;
                    end else begin
                        steps_next = s_tdata;
                        idx_next   = k_last;
                        state_next = ST_SCAN_RD;
                    end
                end
            end
            ST_SCAN_RD: begin
                state_next = ST_SCAN_CK;
            end
            ST_SCAN_CK: begin
                if (below_ceiling) begin
                    wr_en               = 1'b1;
                    wr_data             = cur_val + VAL_W'(1);
                    valid_next[idx_reg] = 1'b1;
                    fill_next           = cur_val + VAL_W'(1);
                    if (is_last_pos) begin
                        steps_next = steps_reg - STEP_W'(1);
                        if (steps_reg == STEP_W'(1)) begin
                            idx_next   = '0;
                            state_next = ST_EMIT_RD;
                        end else begin
                            idx_next   = k_last;
                            state_next = ST_SCAN_RD;
                        end
                    end else begin
                        idx_next   = idx_reg + IDX_W'(1);
                        state_next = ST_FILL;
                    end
                end else if (idx_reg == '0) begin
                    // last combination reached: hold state, flag it
                    exh_next   = 1'b1;
                    state_next = ST_EMIT_RD;
                end else begin
                    idx_next   = idx_reg - IDX_W'(1);
                    state_next = ST_SCAN_RD;
                end
            end
            ST_FILL: begin
                wr_en               = 1'b1;
                valid_next[idx_reg] = 1'b1;
                fill_next           = fill_reg + VAL_W'(1);
                if (is_last_pos) begin
                    steps_next = steps_reg - STEP_W'(1);
                    if (steps_reg == STEP_W'(1)) begin
                        idx_next   = '0;
                        state_next = ST_EMIT_RD;
                    end else begin
                        idx_next   = k_last;
                        state_next = ST_SCAN_RD;
                    end
                end else begin
                    idx_next = idx_reg + IDX_W'(1);
                end
            end
            ST_EMIT_RD: begin
                state_next = ST_EMIT_LD;
            end
            ST_EMIT_LD: begin
                m_valid_next = 1'b1;
                m_elem_next  = cur_val[ELEM_W-1:0];
                m_pos_next   = POS_W'(idx_reg);
                m_last_next  = is_last_pos;
                state_next   = ST_EMIT_WT;
            end
            ST_EMIT_WT: begin
                if (m_tready) begin
                    m_valid_next = 1'b0;
                    if (m_last_reg) begin
                        state_next = ST_IDLE;
                    end else begin
                        idx_next   = idx_reg + IDX_W'(1);
                        state_next = ST_EMIT_RD;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg         <= ST_IDLE;
            idx_reg           <= '0;
            steps_reg         <= '0;
            exh_reg           <= 1'b0;
            valid_reg         <= '0;
            m_valid_reg       <= 1'b0;
            subset_size_reg   <= KSIZE_W'(1);
            universe_size_reg <= NSIZE_W'(256);
        end else begin
            state_reg   <= state_next;
            idx_reg     <= idx_next;
            steps_reg   <= steps_next;
            exh_reg     <= exh_next;
            valid_reg   <= valid_next;
            m_valid_reg <= m_valid_next;
            if (cfg_valid) begin
                case (cfg_index)
                    REG_SUBSET_SIZE:   subset_size_reg   <= cfg_data[KSIZE_W-1:0];
                    REG_UNIVERSE_SIZE: universe_size_reg <= cfg_data[NSIZE_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        fill_reg   <= fill_next;
        m_elem_reg <= m_elem_next;
        m_pos_reg  <= m_pos_next;
        m_last_reg <= m_last_next;
    end

endmodule

`default_nettype wire
